>>> sv/psfp_pkg.sv
// shared types and constants for the particle sensor frame parser
`timescale 1ns / 1ps
`default_nettype none

package psfp_pkg;

    // frame id bytes
    localparam logic [7:0] ID_SHORT = 8'h40;
    localparam logic [7:0] ID_LONG  = 8'h42;
    localparam logic [7:0] ID_NACK  = 8'h96;
    localparam logic [7:0] ID_ACK   = 8'hA5;

    // header bytes
    localparam logic [7:0] SHORT_LEN_BYTE  = 8'h05;
    localparam logic [7:0] SHORT_CMD_BYTE  = 8'h04;
    localparam logic [7:0] LONG_HDR_BYTE1  = 8'h4D;
    localparam logic [7:0] LONG_HDR_BYTE2  = 8'h00;
    localparam logic [7:0] LONG_HDR_BYTE3  = 8'd28;

    // frame kinds
    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_NACK  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    // byte positions
    localparam logic [4:0] POS_FIRST      = 5'd1;
    localparam logic [4:0] POS_SHORT_HDR2 = 5'd2;
    localparam logic [4:0] POS_SHORT_P25H = 5'd3;
    localparam logic [4:0] POS_SHORT_P25L = 5'd4;
    localparam logic [4:0] POS_SHORT_P10H = 5'd5;
    localparam logic [4:0] POS_SHORT_P10L = 5'd6;
    localparam logic [4:0] POS_SHORT_LAST = 5'd7;
    localparam logic [4:0] POS_LONG_HDR2  = 5'd2;
    localparam logic [4:0] POS_LONG_HDR3  = 5'd3;
    localparam logic [4:0] POS_LONG_P25H  = 5'd6;
    localparam logic [4:0] POS_LONG_P25L  = 5'd7;
    localparam logic [4:0] POS_LONG_P10H  = 5'd8;
    localparam logic [4:0] POS_LONG_P10L  = 5'd9;
    localparam logic [4:0] POS_LONG_SUMH  = 5'd30;
    localparam logic [4:0] POS_LONG_LAST  = 5'd31;

    // frame status codes
    localparam logic [2:0] ST_SHORT_OK  = 3'd0;
    localparam logic [2:0] ST_LONG_OK   = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_SUM_BAD   = 3'd3;
    localparam logic [2:0] ST_ACK       = 3'd4;
    localparam logic [2:0] ST_ACK_BAD   = 3'd5;
    localparam logic [2:0] ST_NACK      = 3'd6;
    localparam logic [2:0] ST_NACK_BAD  = 3'd7;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_DISABLE = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic        emit;
        logic [2:0]  frame_status;
        logic [15:0] pm25_reading;
        logic [15:0] pm10_reading;
        logic        reading_valid;
    } t_result;

endpackage

`default_nettype wire

>>> sv/psfp_frame_engine.sv
// frame state, header and checksum checks, stored readings
`timescale 1ns / 1ps
`default_nettype none

module psfp_frame_engine
    import psfp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire t_item   i_item,
    output t_result      o_result
);

    logic [1:0]  r_kind,     n_kind;
    logic        r_active,   n_active;
    logic [4:0]  r_pos,      n_pos;
    logic [15:0] r_sum,      n_sum;
    logic        r_hdr_ok,   n_hdr_ok;
    logic [15:0] r_pm25_cap, n_pm25_cap;
    logic [15:0] r_pm10_cap, n_pm10_cap;
    logic [15:0] r_sum_rx,   n_sum_rx;
    logic [15:0] r_pm25,     n_pm25;
    logic [15:0] r_pm10,     n_pm10;
    logic        r_valid,    n_valid;

    logic [7:0]  w_b;
    logic        w_last;
    logic [2:0]  w_status;
    logic [7:0]  w_neg_sum;

    assign w_b = i_item.rx_byte;

    always_comb begin
        n_kind     = r_kind;
        n_active   = r_active;
        n_pos      = r_pos;
        n_sum      = r_sum;
        n_hdr_ok   = r_hdr_ok;
        n_pm25_cap = r_pm25_cap;
        n_pm10_cap = r_pm10_cap;
        n_sum_rx   = r_sum_rx;
        n_pm25     = r_pm25;
        n_pm10     = r_pm10;
        n_valid    = r_valid;
        w_last     = 1'b0;
        w_status   = ST_SHORT_OK;
        w_neg_sum  = 8'd0;

        if (i_item.req_type == REQ_DISABLE) begin
            n_valid = 1'b0;
        end else if (!r_active) begin
            case (w_b)
                ID_SHORT: begin n_kind = KIND_SHORT; n_active = 1'b1; end
                ID_LONG:  begin n_kind = KIND_LONG;  n_active = 1'b1; end
                ID_NACK:  begin n_kind = KIND_NACK;  n_active = 1'b1; end
                ID_ACK:   begin n_kind = KIND_ACK;   n_active = 1'b1; end
                default:  n_active = 1'b0;
            endcase
            if (n_active) begin
                n_pos    = POS_FIRST;
                n_sum    = {8'd0, w_b};
                n_hdr_ok = 1'b1;
            end
        end else begin
            case (r_kind)
                KIND_SHORT: begin
                    if (r_pos == POS_FIRST && w_b != SHORT_LEN_BYTE) n_hdr_ok = 1'b0;
                    if (r_pos == POS_SHORT_HDR2 && w_b != SHORT_CMD_BYTE) n_hdr_ok = 1'b0;
                    if (r_pos == POS_SHORT_P25H) n_pm25_cap = {w_b, r_pm25_cap[7:0]};
                    if (r_pos == POS_SHORT_P25L) n_pm25_cap = {r_pm25_cap[15:8], w_b};
                    if (r_pos == POS_SHORT_P10H) n_pm10_cap = {w_b, r_pm10_cap[7:0]};
                    if (r_pos == POS_SHORT_P10L) n_pm10_cap = {r_pm10_cap[15:8], w_b};
                    if (r_pos < POS_SHORT_LAST) n_sum = r_sum + {8'd0, w_b};
                    if (r_pos == POS_SHORT_LAST) n_sum_rx = {8'd0, w_b};
                    w_last = (r_pos == POS_SHORT_LAST);
                end
                KIND_LONG: begin
                    if (r_pos == POS_FIRST && w_b != LONG_HDR_BYTE1) n_hdr_ok = 1'b0;
                    if (r_pos == POS_LONG_HDR2 && w_b != LONG_HDR_BYTE2) n_hdr_ok = 1'b0;
                    if (r_pos == POS_LONG_HDR3 && w_b != LONG_HDR_BYTE3) n_hdr_ok = 1'b0;
                    if (r_pos == POS_LONG_P25H) n_pm25_cap = {w_b, r_pm25_cap[7:0]};
                    if (r_pos == POS_LONG_P25L) n_pm25_cap = {r_pm25_cap[15:8], w_b};
                    if (r_pos == POS_LONG_P10H) n_pm10_cap = {w_b, r_pm10_cap[7:0]};
                    if (r_pos == POS_LONG_P10L) n_pm10_cap = {r_pm10_cap[15:8], w_b};
                    if (r_pos < POS_LONG_SUMH) n_sum = r_sum + {8'd0, w_b};
                    if (r_pos == POS_LONG_SUMH) n_sum_rx = {w_b, 8'd0};
                    if (r_pos == POS_LONG_LAST) n_sum_rx = {r_sum_rx[15:8], w_b};
                    w_last = (r_pos == POS_LONG_LAST);
                end
                default: begin
                    // ack and nack frames end on their second byte
                    w_last = (r_pos == POS_FIRST);
                end
            endcase

            w_neg_sum = 8'd0 - n_sum[7:0];

            if (w_last) begin
                case (r_kind)
                    KIND_SHORT: begin
                        if (!n_hdr_ok) begin
                            w_status = ST_MALFORMED;
                        end else if (n_sum_rx != {8'd0, w_neg_sum}) begin
                            w_status = ST_SUM_BAD;
                        end else begin
                            w_status = ST_SHORT_OK;
                            n_pm25   = n_pm25_cap;
                            n_pm10   = n_pm10_cap;
                            n_valid  = 1'b1;
                        end
                    end
                    KIND_LONG: begin
                        if (!n_hdr_ok) begin
                            w_status = ST_MALFORMED;
                        end else if (n_sum_rx != n_sum) begin
                            w_status = ST_SUM_BAD;
                        end else begin
                            w_status = ST_LONG_OK;
                            n_pm25   = n_pm25_cap;
                            n_pm10   = n_pm10_cap;
                            n_valid  = 1'b1;
                        end
                    end
                    KIND_NACK: w_status = (w_b == ID_NACK) ? ST_NACK : ST_NACK_BAD;
                    default:   w_status = (w_b == ID_ACK) ? ST_ACK : ST_ACK_BAD;
                endcase
                // back to idle
                n_kind     = KIND_SHORT;
                n_active   = 1'b0;
                n_pos      = 5'd0;
                n_sum      = 16'd0;
                n_hdr_ok   = 1'b1;
                n_pm25_cap = 16'd0;
                n_pm10_cap = 16'd0;
                n_sum_rx   = 16'd0;
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_SHORT;
            r_active   <= 1'b0;
            r_pos      <= 5'd0;
            r_sum      <= 16'd0;
            r_hdr_ok   <= 1'b1;
            r_pm25_cap <= 16'd0;
            r_pm10_cap <= 16'd0;
            r_sum_rx   <= 16'd0;
            r_pm25     <= 16'd0;
            r_pm10     <= 16'd0;
            r_valid    <= 1'b0;
        end else if (i_step) begin
            r_kind     <= n_kind;
            r_active   <= n_active;
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_hdr_ok   <= n_hdr_ok;
            r_pm25_cap <= n_pm25_cap;
            r_pm10_cap <= n_pm10_cap;
            r_sum_rx   <= n_sum_rx;
            r_pm25     <= n_pm25;
            r_pm10     <= n_pm10;
            r_valid    <= n_valid;
        end
    end

    assign o_result.emit          = w_last;
    assign o_result.frame_status  = w_status;
    assign o_result.pm25_reading  = n_pm25;
    assign o_result.pm10_reading  = n_pm10;
    assign o_result.reading_valid = n_valid;

endmodule

`default_nettype wire

>>> sv/particle_sensor_frame_parser_core.sv
// top level: input register, frame engine, result register
// path: a request waits in the input register until the frame engine can step, then its status is registered
// throughput: one request per cycle while the result register is not stalled, set by the single-pass frame engine
// a status result appears only on the last byte of a frame
// reset (synchronous, active low) returns the engine to idle with stored readings zero and not valid
`timescale 1ns / 1ps
`default_nettype none

module particle_sensor_frame_parser_core
    import psfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_frame_status,
    output logic [15:0]      o_pm25_reading,
    output logic [15:0]      o_pm10_reading,
    output logic             o_reading_valid
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [15:0] r_pm25;
    logic [15:0] r_pm10;
    logic        r_rd_valid;

    logic        w_fire;
    t_result     w_result;

    // engine steps when the result register is free or being emptied
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.req_type <= i_req_type;
            r_in.rx_byte  <= i_rx_byte;
        end
    end

    psfp_frame_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_fire),
        .i_item   (r_in),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_result.emit) begin
            r_status   <= w_result.frame_status;
            r_pm25     <= w_result.pm25_reading;
            r_pm10     <= w_result.pm10_reading;
            r_rd_valid <= w_result.reading_valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_status  = r_status;
    assign o_pm25_reading  = r_pm25;
    assign o_pm10_reading  = r_pm10;
    assign o_reading_valid = r_rd_valid;

    // a held request is not consumed while the result register is stalled
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> r_in_valid)
        else $error("request consumed while result stalled");

    // every emitted status lands in the result register
    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.emit) |=> r_out_valid)
        else $error("emitted status lost");

    // a good reading status always comes with the valid flag set
    a_ok_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_SHORT_OK || r_status == ST_LONG_OK))
        |-> r_rd_valid)
        else $error("good frame without valid reading");

    // a disable request never produces a status
    a_disable_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.req_type == REQ_DISABLE) |-> !w_result.emit)
        else $error("disable request produced a status");

endmodule

`default_nettype wire

>>> tb/particle_sensor_frame_parser_core_tb.sv
// testbench for the particle sensor frame parser: predictor scoreboard, frame stimulus, checks
`timescale 1ns / 1ps

module particle_sensor_frame_parser_core_tb
    import psfp_pkg::*;
();

    localparam int SHORT_FRAME_BYTES = 8;
    localparam int LONG_FRAME_BYTES  = 32;
    localparam int REPLY_FRAME_BYTES = 2;
    localparam int HDR_INTACT        = 0;
    localparam int MAX_REPORTS       = 10;
    localparam int RANDOM_ITEMS      = 150;
    localparam int PRESSURE_AT       = 30;
    localparam int PRESSURE_ACKS     = 20;
    localparam int QUIET_TAIL        = 40;
    localparam int HOLD_CYCLES       = 300;
    localparam int DRAIN_CYCLES      = 10;
    localparam int WATCHDOG_LIMIT    = 3000;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] pm25;
        logic [15:0] pm10;
        logic        valid;
    } reading_t;

    class frame_scoreboard;
        reading_t    expected_readings[$];
        int          mismatches = 0;
        int          results_checked = 0;
        int          requests_noted = 0;
        int          status_count[8];
        logic [1:0]  cur_kind = KIND_SHORT;
        bit          in_frame = 1'b0;
        logic [4:0]  byte_idx = '0;
        logic [15:0] sum_acc = '0;
        bit          header_good = 1'b1;
        logic [7:0]  reply_byte = '0;
        logic [15:0] pm25_part = '0;
        logic [15:0] pm10_part = '0;
        logic [15:0] sum_field = '0;
        logic [15:0] pm25_held = '0;
        logic [15:0] pm10_held = '0;
        bit          held_valid = 1'b0;

        function void drop_frame();
            cur_kind    = KIND_SHORT;
            in_frame    = 1'b0;
            byte_idx    = '0;
            sum_acc     = '0;
            header_good = 1'b1;
            reply_byte  = '0;
            pm25_part   = '0;
            pm10_part   = '0;
            sum_field   = '0;
        endfunction

        function void keep_reading();
            pm25_held  = pm25_part;
            pm10_held  = pm10_part;
            held_valid = 1'b1;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_request(logic req, logic [7:0] b);
            logic [4:0] p;
            logic [7:0] neg;
            logic [2:0] st;
            int         flen;
            reading_t   r;
            requests_noted++;
            if (req == REQ_DISABLE) begin
                held_valid = 1'b0;
                return;
            end
            if (!in_frame) begin
                case (b)
                    ID_SHORT: cur_kind = KIND_SHORT;
                    ID_LONG:  cur_kind = KIND_LONG;
                    ID_NACK:  cur_kind = KIND_NACK;
                    ID_ACK:   cur_kind = KIND_ACK;
                    default:  return;
                endcase
                in_frame    = 1'b1;
                byte_idx    = POS_FIRST;
                sum_acc     = {8'h00, b};
                header_good = 1'b1;
                return;
            end
            p = byte_idx;
            if (p == POS_FIRST) reply_byte = b;
            if (cur_kind == KIND_SHORT) begin
                if (p == POS_FIRST && b != SHORT_LEN_BYTE) header_good = 1'b0;
                if (p == POS_SHORT_HDR2 && b != SHORT_CMD_BYTE) header_good = 1'b0;
                if (p == POS_SHORT_P25H) pm25_part[15:8] = b;
                if (p == POS_SHORT_P25L) pm25_part[7:0] = b;
                if (p == POS_SHORT_P10H) pm10_part[15:8] = b;
                if (p == POS_SHORT_P10L) pm10_part[7:0] = b;
                if (p < POS_SHORT_LAST) sum_acc += b;
                if (p == POS_SHORT_LAST) sum_field = {8'h00, b};
                flen = SHORT_FRAME_BYTES;
            end else if (cur_kind == KIND_LONG) begin
                if (p == POS_FIRST && b != LONG_HDR_BYTE1) header_good = 1'b0;
                if (p == POS_LONG_HDR2 && b != LONG_HDR_BYTE2) header_good = 1'b0;
                if (p == POS_LONG_HDR3 && b != LONG_HDR_BYTE3) header_good = 1'b0;
                if (p == POS_LONG_P25H) pm25_part[15:8] = b;
                if (p == POS_LONG_P25L) pm25_part[7:0] = b;
                if (p == POS_LONG_P10H) pm10_part[15:8] = b;
                if (p == POS_LONG_P10L) pm10_part[7:0] = b;
                if (p < POS_LONG_SUMH) sum_acc += b;
                if (p == POS_LONG_SUMH) sum_field = {b, 8'h00};
                if (p == POS_LONG_LAST) sum_field[7:0] = b;
                flen = LONG_FRAME_BYTES;
            end else begin
                flen = REPLY_FRAME_BYTES;
            end
            if (int'(p) + 1 < flen) begin
                byte_idx = p + 5'd1;
                return;
            end
            case (cur_kind)
                KIND_SHORT: begin
                    // short frame carries the two's complement of the low sum byte
                    neg = 8'd0 - sum_acc[7:0];
                    if (!header_good) st = ST_MALFORMED;
                    else if (sum_field != {8'h00, neg}) st = ST_SUM_BAD;
                    else begin
                        st = ST_SHORT_OK;
                        keep_reading();
                    end
                end
                KIND_LONG: begin
                    if (!header_good) st = ST_MALFORMED;
                    else if (sum_field != sum_acc) st = ST_SUM_BAD;
                    else begin
                        st = ST_LONG_OK;
                        keep_reading();
                    end
                end
                KIND_NACK: st = (reply_byte == ID_NACK) ? ST_NACK : ST_NACK_BAD;
                default:   st = (reply_byte == ID_ACK) ? ST_ACK : ST_ACK_BAD;
            endcase
            drop_frame();
            r = '{st, pm25_held, pm10_held, held_valid};
            expected_readings.push_back(r);
            status_count[st]++;
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            results_checked++;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d pm2.5 %h pm10 %h valid %0d",
                             got.status, got.pm25, got.pm10, got.valid);
                return;
            end
            want = expected_readings.pop_front();
            if (got.status !== want.status || got.pm25 !== want.pm25 ||
                got.pm10 !== want.pm10 || got.valid !== want.valid) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: status exp %0d got %0d, pm2.5 exp %h got %h, %s",
                             results_checked, want.status, got.status, want.pm25, got.pm25,
                             $sformatf("pm10 exp %h got %h, valid exp %0d got %0d",
                                       want.pm10, got.pm10, want.valid, got.valid));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_req_type = REQ_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_frame_status;
    logic [15:0] o_pm25_reading;
    logic [15:0] o_pm10_reading;
    logic        o_reading_valid;

    frame_scoreboard sb = new;

    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    bit hold_req = 1'b0;
    bit sprinkle_disables = 1'b0;
    int disable_at = -1;

    particle_sensor_frame_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_pm25_reading (o_pm25_reading),
        .o_pm10_reading (o_pm10_reading),
        .o_reading_valid(o_reading_valid)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // offer one request and hold it until taken, then maybe pause
    task automatic send_req(input logic req, input logic [7:0] b);
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(req, b);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_reply(input logic [7:0] id, input bit good);
        send_req(REQ_BYTE, id);
        send_req(REQ_BYTE, good ? id : id ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic send_reading(input bit is_long, input logic [15:0] pm25,
                                input logic [15:0] pm10, input int bad_hdr, input bit bad_sum);
        logic [7:0]  fb [0:31];
        logic [15:0] total;
        logic [7:0]  cks;
        int          n;
        n = is_long ? LONG_FRAME_BYTES : SHORT_FRAME_BYTES;
        total = '0;
        for (int i = 0; i < LONG_FRAME_BYTES; i++) fb[i] = 8'($urandom_range(0, 255));
        if (is_long) begin
            fb[0] = ID_LONG;
            fb[POS_FIRST] = LONG_HDR_BYTE1;
            fb[POS_LONG_HDR2] = LONG_HDR_BYTE2;
            fb[POS_LONG_HDR3] = LONG_HDR_BYTE3;
            fb[POS_LONG_P25H] = pm25[15:8];
            fb[POS_LONG_P25L] = pm25[7:0];
            fb[POS_LONG_P10H] = pm10[15:8];
            fb[POS_LONG_P10L] = pm10[7:0];
        end else begin
            fb[0] = ID_SHORT;
            fb[POS_FIRST] = SHORT_LEN_BYTE;
            fb[POS_SHORT_HDR2] = SHORT_CMD_BYTE;
            fb[POS_SHORT_P25H] = pm25[15:8];
            fb[POS_SHORT_P25L] = pm25[7:0];
            fb[POS_SHORT_P10H] = pm10[15:8];
            fb[POS_SHORT_P10L] = pm10[7:0];
        end
        if (bad_hdr != HDR_INTACT) fb[bad_hdr] ^= 8'($urandom_range(1, 255));
        if (is_long) begin
            for (int i = 0; i < POS_LONG_SUMH; i++) total += fb[i];
            if (bad_sum) total ^= 16'($urandom_range(1, 65535));
            fb[POS_LONG_SUMH] = total[15:8];
            fb[POS_LONG_LAST] = total[7:0];
        end else begin
            for (int i = 0; i < POS_SHORT_LAST; i++) total += fb[i];
            cks = 8'd0 - total[7:0];
            if (bad_sum) cks ^= 8'($urandom_range(1, 255));
            fb[POS_SHORT_LAST] = cks;
        end
        for (int i = 0; i < n; i++) begin
            if (i == disable_at || (sprinkle_disables && $urandom_range(0, 39) == 0))
                send_req(REQ_DISABLE, 8'($urandom_range(0, 255)));
            send_req(REQ_BYTE, fb[i]);
        end
    endtask

    task automatic random_frame();
        int         sel;
        int         flaw;
        int         n;
        bit         is_long;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            is_long = (sel >= 35);
            flaw = $urandom_range(0, 9);
            send_reading(is_long, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         (flaw == 0 || flaw == 2) ? $urandom_range(1, is_long ? 3 : 2)
                                                  : HDR_INTACT,
                         flaw == 1 || flaw == 2);
        end else if (sel < 60) begin
            send_reply(ID_ACK, $urandom_range(0, 2) != 0);
        end else if (sel < 70) begin
            send_reply(ID_NACK, $urandom_range(0, 2) != 0);
        end else if (sel < 78) begin
            // idle noise that cannot open a frame
            do b = 8'($urandom_range(0, 255));
            while (b == ID_SHORT || b == ID_LONG || b == ID_NACK || b == ID_ACK);
            send_req(REQ_BYTE, b);
        end else if (sel < 85) begin
            send_req(REQ_DISABLE, 8'($urandom_range(0, 255)));
        end else if (sel < 92) begin
            // cut-off frame, the following bytes get absorbed into it
            is_long = $urandom_range(0, 1);
            send_req(REQ_BYTE, is_long ? ID_LONG : ID_SHORT);
            n = $urandom_range(1, is_long ? LONG_FRAME_BYTES - 2 : SHORT_FRAME_BYTES - 2);
            repeat (n) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!receiver_gaps || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        reading_t seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = '{o_frame_status, o_pm25_reading, o_pm10_reading, o_reading_valid};
            sb.check_reading(seen);
        end
    end

    initial begin
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int  start;
        bit  pressed = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cases
        send_req(REQ_BYTE, 8'h00);
        send_req(REQ_BYTE, 8'hFF);
        send_reply(ID_ACK, 1'b1);
        send_reply(ID_ACK, 1'b0);
        send_reply(ID_NACK, 1'b1);
        send_reply(ID_NACK, 1'b0);
        send_reading(1'b0, 16'h0000, 16'h0000, HDR_INTACT, 1'b0);
        send_reading(1'b0, 16'hFFFF, 16'hFFFF, HDR_INTACT, 1'b0);
        send_reading(1'b0, 16'h1234, 16'h5678, POS_FIRST, 1'b0);
        send_reading(1'b0, 16'h1234, 16'h5678, POS_SHORT_HDR2, 1'b0);
        send_reading(1'b0, 16'h8001, 16'h7FFE, HDR_INTACT, 1'b1);
        send_reading(1'b0, 16'h4242, 16'h9696, POS_SHORT_HDR2, 1'b1);
        send_req(REQ_DISABLE, 8'hFF);
        send_reading(1'b1, 16'hFFFF, 16'hFFFF, HDR_INTACT, 1'b0);
        send_reading(1'b1, 16'h0000, 16'h0000, HDR_INTACT, 1'b0);
        send_reading(1'b1, 16'hAAAA, 16'h5555, POS_FIRST, 1'b0);
        send_reading(1'b1, 16'hAAAA, 16'h5555, POS_LONG_HDR2, 1'b0);
        send_reading(1'b1, 16'hAAAA, 16'h5555, POS_LONG_HDR3, 1'b0);
        send_reading(1'b1, 16'h0F0F, 16'hF0F0, HDR_INTACT, 1'b1);
        send_reading(1'b1, 16'h0F0F, 16'hF0F0, POS_LONG_HDR3, 1'b1);
        // disable in the middle of a good frame, then again while idle
        disable_at = 4;
        send_reading(1'b0, 16'h00FF, 16'hFF00, HDR_INTACT, 1'b0);
        disable_at = -1;
        send_req(REQ_DISABLE, 8'h00);

        // random part
        sprinkle_disables = 1'b1;
        start = sb.requests_noted;
        while (sb.requests_noted - start < RANDOM_ITEMS) begin
            if (!pressed && sb.requests_noted - start > PRESSURE_AT) begin
                // back up the result side with a burst of short replies
                hold_req = 1'b1;
                sender_gaps = 1'b0;
                repeat (PRESSURE_ACKS) send_reply(ID_ACK, 1'b1);
                sender_gaps = 1'b1;
                pressed = 1'b1;
            end
            if (sb.requests_noted - start > RANDOM_ITEMS - QUIET_TAIL) begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
            random_frame();
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests and %0d frame results, %0d mismatches",
                 sb.requests_noted, sb.results_checked, sb.mismatches);
        $display("status mix: short ok %0d, long ok %0d, malformed %0d, bad sum %0d, %s",
                 sb.status_count[ST_SHORT_OK], sb.status_count[ST_LONG_OK],
                 sb.status_count[ST_MALFORMED], sb.status_count[ST_SUM_BAD],
                 $sformatf("ack %0d/%0d, nack %0d/%0d",
                           sb.status_count[ST_ACK], sb.status_count[ST_ACK_BAD],
                           sb.status_count[ST_NACK], sb.status_count[ST_NACK_BAD]));
        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> particle_sensor_frame_parser_core.f
sv/psfp_pkg.sv
sv/psfp_frame_engine.sv
sv/particle_sensor_frame_parser_core.sv
tb/particle_sensor_frame_parser_core_tb.sv
